// ===== rtl/wgen_pkg.sv =====
// ----------------------------------------------------------------------------
// wgen_pkg
// shared constants, types and the sine table builder of the waveform generator
// ----------------------------------------------------------------------------
package wgen_pkg;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int REG_BITS      = 16;
    localparam int TIME_BITS     = 32;
    localparam int PHASE_BITS    = 16;

    localparam logic REG_PERIOD   = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    localparam logic [REG_BITS-1:0] PERIOD_RESET   = 16'd5000;
    localparam logic [REG_BITS-1:0] INTERVAL_RESET = 16'd10;

    localparam int DVD_BITS  = TIME_BITS + PHASE_BITS;
    localparam int DIV_STEPS = DVD_BITS / 2;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_ROM,
        BK_OUT
    } back_state_t;

    // sin(pi/2 * j / quart) in q1.30, quart = 2^(tab_bits-2)
    function automatic longint quarter_sin(input int j, input int tab_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (PI_Q30 * 64'(j)) >> (tab_bits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30))
        begin
            sum = longint'(ONE_Q30);
        end
        return sum;
    endfunction

    // offset sine code for table entry k
    function automatic logic [15:0] sine_entry(input int k, input int dac_bits,
                                               input int tab_bits);
        int          quart;
        int          q;
        int          r;
        longint      s;
        logic [63:0] v;
        logic [63:0] maxc;
        logic [63:0] prod;
        quart = 1 << (tab_bits - 2);
        q     = k >> (tab_bits - 2);
        r     = k & (quart - 1);
        case (q & 3)
            0:       s = quarter_sin(r, tab_bits);
            1:       s = quarter_sin(quart - r, tab_bits);
            2:       s = -quarter_sin(r, tab_bits);
            default: s = -quarter_sin(quart - r, tab_bits);
        endcase
        v    = 64'(longint'(ONE_Q30) + s);
        maxc = (64'd1 << dac_bits) - 64'd1;
        prod = (maxc * v) >> 31;
        return prod[15:0];
    endfunction

endpackage

// ===== rtl/multi_waveform_generator_core.sv =====
// an accepted timestamp that updates goes through the queue, the radix-4 phase divider,
// a rom read and an output load; the next one is taken from the queue only after the
// output load, which waits while the previous result has not been popped
// timestamps that do not update are taken one per cycle while the queue has room
// reset: period 5000 ms, interval 10 ms, last update time 0, queues empty
// ----------------------------------------------------------------------------
// multi_waveform_generator_core
// four-shape function generator driven by a millisecond timestamp
// ----------------------------------------------------------------------------
module multi_waveform_generator_core
#(
    parameter int DAC_BITS        = 12,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         now_ms,
    output logic                empty,
    input  logic                pop,
    output logic [15:0]         phase_fraction,
    output logic [DAC_BITS-1:0] saw_code,
    output logic [DAC_BITS-1:0] tri_code,
    output logic [DAC_BITS-1:0] square_code,
    output logic [DAC_BITS-1:0] sine_code
);
    import wgen_pkg::*;

    logic [REG_BITS-1:0]  period_reg;
    logic [REG_BITS-1:0]  interval_reg;
    logic                 cfg_wr;
    logic                 q_full;
    logic                 q_wr_en;
    logic [TIME_BITS-1:0] q_wr_data;
    logic                 q_rd_en;
    logic                 q_valid;
    logic [TIME_BITS-1:0] q_rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_PERIOD:   prdata = {{(CFG_DATA_BITS-REG_BITS){1'b0}}, period_reg};
            REG_INTERVAL: prdata = {{(CFG_DATA_BITS-REG_BITS){1'b0}}, interval_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PERIOD)
            begin
                period_reg <= pwdata[REG_BITS-1:0];
            end
            else
            begin
                interval_reg <= pwdata[REG_BITS-1:0];
            end
        end
    end

    wgen_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .now_ms             (now_ms),
        .full               (full),
        .update_interval_ms (interval_reg),
        .q_full             (q_full),
        .q_wr_en            (q_wr_en),
        .q_wr_data          (q_wr_data)
    );

    wgen_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    wgen_back
    #(
        .DAC_BITS        (DAC_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .period_ms      (period_reg),
        .q_valid        (q_valid),
        .q_data         (q_rd_data),
        .q_rd_en        (q_rd_en),
        .empty          (empty),
        .pop            (pop),
        .phase_fraction (phase_fraction),
        .saw_code       (saw_code),
        .tri_code       (tri_code),
        .square_code    (square_code),
        .sine_code      (sine_code)
    );

endmodule

// ===== rtl/wgen_fifo.sv =====
// ----------------------------------------------------------------------------
// wgen_fifo
// two-entry timestamp queue between the front and the back
// ----------------------------------------------------------------------------
module wgen_fifo
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [31:0] wr_data,
    output logic        full,
    input  logic        rd_en,
    output logic        rd_valid,
    output logic [31:0] rd_data
);
    import wgen_pkg::*;

    logic [TIME_BITS-1:0] mem_reg [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/wgen_front.sv =====
// ----------------------------------------------------------------------------
// wgen_front
// takes timestamps, checks the update interval and queues the ones that update
// ----------------------------------------------------------------------------
module wgen_front
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [31:0] now_ms,
    output logic        full,
    input  logic [15:0] update_interval_ms,
    input  logic        q_full,
    output logic        q_wr_en,
    output logic [31:0] q_wr_data
);
    import wgen_pkg::*;

    logic [TIME_BITS-1:0] last_time_reg;
    logic [TIME_BITS-1:0] last_time_next;
    logic [TIME_BITS-1:0] elapsed;
    logic                 accept;
    logic                 due;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign elapsed   = now_ms - last_time_reg;
    assign due       = (elapsed >= {{(TIME_BITS-REG_BITS){1'b0}}, update_interval_ms});
    assign q_wr_en   = accept && due;
    assign q_wr_data = now_ms;

    always_comb
    begin
        last_time_next = last_time_reg;
        if (accept && due)
        begin
            last_time_next = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else
        begin
            last_time_reg <= last_time_next;
        end
    end

endmodule

// ===== rtl/wgen_back.sv =====
// ----------------------------------------------------------------------------
// wgen_back
// phase divider, waveform shaping, sine rom and output register
// ----------------------------------------------------------------------------
module wgen_back
#(
    parameter int DAC_BITS        = 12,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         period_ms,
    input  logic                q_valid,
    input  logic [31:0]         q_data,
    output logic                q_rd_en,
    output logic                empty,
    input  logic                pop,
    output logic [15:0]         phase_fraction,
    output logic [DAC_BITS-1:0] saw_code,
    output logic [DAC_BITS-1:0] tri_code,
    output logic [DAC_BITS-1:0] square_code,
    output logic [DAC_BITS-1:0] sine_code
);
    import wgen_pkg::*;

    localparam int TAB_N = 1 << SINE_TABLE_BITS;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [DVD_BITS-1:0]   dvd_reg;
    logic [REG_BITS-1:0]   rem_reg;
    logic [PHASE_BITS-1:0] quo_reg;
    logic [REG_BITS-1:0]   per_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [DAC_BITS-1:0]   rom_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PHASE_BITS-1:0] phase_out_reg;
    logic [DAC_BITS-1:0]   saw_out_reg;
    logic [DAC_BITS-1:0]   tri_out_reg;
    logic [DAC_BITS-1:0]   sq_out_reg;
    logic [DAC_BITS-1:0]   sine_out_reg;

    logic [DAC_BITS-1:0]   sine_rom [TAB_N];
    logic [16:0]           step_a;
    logic [16:0]           step_b;
    logic                  load_out;
    logic [PHASE_BITS+DAC_BITS-1:0] saw_prod;
    logic [16:0]                    tri_sel;
    logic [PHASE_BITS+DAC_BITS:0]   tri_prod;
    logic [DAC_BITS-1:0]            saw_val;
    logic [DAC_BITS-1:0]            tri_val;
    logic [DAC_BITS-1:0]            sq_val;

    for (genvar k = 0; k < TAB_N; k++)
    begin : g_rom
        localparam logic [15:0] ENTRY = sine_entry(k, DAC_BITS, SINE_TABLE_BITS);
        assign sine_rom[k] = ENTRY[DAC_BITS-1:0];
    end

    function automatic logic [16:0] div_step(input logic [15:0] r, input logic b,
                                             input logic [15:0] d);
        logic [16:0] t;
        logic [16:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            return {1'b1, diff[15:0]};
        end
        return {1'b0, t[15:0]};
    endfunction

    assign step_a = div_step(rem_reg, dvd_reg[DVD_BITS-1], per_reg);
    assign step_b = div_step(step_a[15:0], dvd_reg[DVD_BITS-2], per_reg);

    // code shaping from the finished phase
    assign saw_prod = {quo_reg, {DAC_BITS{1'b0}}} - {{DAC_BITS{1'b0}}, quo_reg};
    assign tri_sel  = quo_reg[15] ? (17'h10000 - {1'b0, quo_reg}) : {1'b0, quo_reg};
    assign tri_prod = {tri_sel, {DAC_BITS{1'b0}}} - {{DAC_BITS{1'b0}}, tri_sel};
    assign saw_val  = saw_prod[PHASE_BITS +: DAC_BITS];
    assign tri_val  = tri_prod[PHASE_BITS-1 +: DAC_BITS];
    assign sq_val   = quo_reg[15] ? '0 : '1;

    assign empty          = !out_valid_reg;
    assign phase_fraction = phase_out_reg;
    assign saw_code       = saw_out_reg;
    assign tri_code       = tri_out_reg;
    assign square_code    = sq_out_reg;
    assign sine_code      = sine_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        q_rd_en        = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_rd_en    = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = BK_ROM;
                end
            end
            BK_ROM:
            begin
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == BK_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                dvd_reg <= {q_data, {PHASE_BITS{1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
                per_reg <= (period_ms == '0) ? REG_BITS'(1) : period_ms;
            end
            BK_DIV:
            begin
                dvd_reg <= {dvd_reg[DVD_BITS-3:0], 2'b00};
                rem_reg <= step_b[15:0];
                quo_reg <= {quo_reg[PHASE_BITS-3:0], step_a[16], step_b[16]};
            end
            BK_ROM:
            begin
                rom_data_reg <= sine_rom[quo_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]];
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            phase_out_reg <= quo_reg;
            saw_out_reg   <= saw_val;
            tri_out_reg   <= tri_val;
            sq_out_reg    <= sq_val;
            sine_out_reg  <= rom_data_reg;
        end
    end

endmodule
